// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
// No dependencies; every other file of the block but spq_ram uses it.
package spq_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 2;
    localparam int OCC_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_PLACE,
        ST_HEAD_RD,
        ST_HEAD_WAIT,
        ST_RESP
    } state_t;

    // Store write source and target (logical positions, head is zero)
    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW_ZERO,
        WR_NEW_ABOVE,
        WR_SHIFT_UP
    } wr_cmd_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_LAST,
        RD_PREV,
        RD_HEAD
    } rd_cmd_t;

    typedef struct packed {
        logic    take;
        wr_cmd_t wr;
        rd_cmd_t rd;
        logic    set_ok;
        logic    ok_val;
        logic    cnt_inc;
        logic    pop;
        logic    clr;
        logic    head_zero;
        logic    head_cap;
        logic    out_load;
    } spq_cmd_t;

    typedef struct packed {
        logic in_valid;
        op_t  op;
        logic full;
        logic empty;
        logic idx_zero;
        logic keep;
        logic out_free;
    } spq_status_t;

endpackage

// ===== hdl/spq_req_if.sv =====
// Request channel: operation, data word and priority with valid/ready.
// Depends on spq_pkg.
interface spq_req_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] data_in;
    logic signed [WORD_W-1:0] priority_in;

    modport source (output valid, operation, data_in, priority_in, input ready);
    modport sink   (input valid, operation, data_in, priority_in, output ready);
endinterface

// ===== hdl/spq_rsp_if.sv =====
// Response channel: status, head word and occupancy with valid/ready.
// Depends on spq_pkg.
interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [WORD_W-1:0] head_data;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;

    modport source (output valid, accepted, head_data, occupancy, is_empty, input ready);
    modport sink   (input valid, accepted, head_data, occupancy, is_empty, output ready);
endinterface

// ===== hdl/stable_priority_queue.sv =====
// Stable priority queue of up to DEPTH words, highest priority first and equal
// priorities in arrival order, stored as a sorted ring in one RAM. Each request
// yields one response word. An enqueue into a nonempty queue scans from tail to
// head, moving each entry of lower priority up by one with one RAM read and one
// write per step, until a compare stops the scan or the word is written at the
// head. One request is worked at a time; a new one is accepted in the cycle after
// the last response is loaded, even while that response waits.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl and spq_datapath.
module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   request,
    spq_rsp_if.source response
);
    import spq_pkg::*;

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cmd      (cmd),
        .status   (status)
    );
endmodule

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/spq_ctrl.sv =====
// Sequencer for the queue: decodes the operation, steps the insertion scan,
// fetches the new head and hands the word to the response register. Uses spq_pkg.
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::spq_status_t status,
    output spq_pkg::spq_cmd_t    cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr     = WR_NONE;
        cmd.rd     = RD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.set_ok = 1'b1;
                state_next = ST_HEAD_RD;
                case (status.op)
                    OP_ENQUEUE:
                    begin
                        cmd.ok_val = !status.full;
                        if (!status.full)
                        begin
                            if (status.empty)
                            begin
                                cmd.wr      = WR_NEW_ZERO;
                                cmd.cnt_inc = 1'b1;
                            end
                            else
                            begin
                                // walk from the tail toward the head
                                cmd.rd     = RD_LAST;
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    OP_DEQUEUE:
                    begin
                        cmd.ok_val = !status.empty;
                        cmd.pop    = !status.empty;
                    end
                    OP_PEEK:
                    begin
                        cmd.ok_val = !status.empty;
                    end
                    OP_CLEAR:
                    begin
                        cmd.ok_val = 1'b1;
                        cmd.clr    = 1'b1;
                    end
                    default:
                    begin
                        cmd.ok_val = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (status.keep)
                begin
                    // entry stays: new word lands right behind it
                    cmd.wr      = WR_NEW_ABOVE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_HEAD_RD;
                end
                else
                begin
                    cmd.wr = WR_SHIFT_UP;
                    if (status.idx_zero)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        cmd.rd = RD_PREV;
                    end
                end
            end
            ST_PLACE:
            begin
                cmd.wr      = WR_NEW_ZERO;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                if (status.empty)
                begin
                    cmd.head_zero = 1'b1;
                    state_next    = ST_RESP;
                end
                else
                begin
                    cmd.rd     = RD_HEAD;
                    state_next = ST_HEAD_WAIT;
                end
            end
            ST_HEAD_WAIT:
            begin
                cmd.head_cap = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/spq_datapath.sv =====
// Queue storage as a circular sorted buffer in RAM, with head pointer, count,
// scan index and the response register. Uses spq_pkg, spq_ram and both channels.
module spq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    spq_req_if.sink              request,
    spq_rsp_if.source            response,
    input  spq_pkg::spq_cmd_t    cmd,
    output spq_pkg::spq_status_t status
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 2 * WORD_W;

    op_t                      op_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] prio_reg;
    logic [AW-1:0]            head_ptr_reg;
    logic [AW-1:0]            head_ptr_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [AW-1:0]            idx_reg;
    logic [AW-1:0]            idx_next;
    logic                     ok_reg;
    logic [WORD_W-1:0]        head_word_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic                     rsp_accepted_reg;
    logic [WORD_W-1:0]        rsp_head_reg;
    logic [OCC_W-1:0]         rsp_occ_reg;
    logic                     rsp_empty_reg;

    logic                     wr_en;
    logic [AW-1:0]            wr_lidx;
    logic [EW-1:0]            wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_lidx;
    logic [EW-1:0]            rd_data;
    logic [31:0]              count_wide;
    logic                     in_take;

    // logical position to RAM address, wrapping around the ring
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [AW-1:0] lidx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign in_take       = request.valid && cmd.take;
    assign request.ready = cmd.take;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= op_t'(request.operation);
            word_reg <= request.data_in;
            prio_reg <= request.priority_in;
        end
    end

    // read side
    always_comb
    begin
        rd_en    = 1'b1;
        rd_lidx  = '0;
        idx_next = idx_reg;
        case (cmd.rd)
            RD_LAST:
            begin
                rd_lidx  = AW'(count_reg - CW'(1));
                idx_next = rd_lidx;
            end
            RD_PREV:
            begin
                rd_lidx  = idx_reg - AW'(1);
                idx_next = rd_lidx;
            end
            RD_HEAD:
            begin
                rd_lidx = '0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // write side
    always_comb
    begin
        wr_en   = 1'b1;
        wr_lidx = idx_reg + AW'(1);
        wr_data = {prio_reg, word_reg};
        case (cmd.wr)
            WR_NEW_ZERO:
            begin
                wr_lidx = '0;
            end
            WR_NEW_ABOVE:
            begin
                wr_data = {prio_reg, word_reg};
            end
            WR_SHIFT_UP:
            begin
                wr_data = rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (to_phys(head_ptr_reg, wr_lidx)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (to_phys(head_ptr_reg, rd_lidx)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        count_next    = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.pop)
        begin
            count_next    = count_reg - CW'(1);
            head_ptr_next = (head_ptr_reg == AW'(DEPTH - 1)) ? '0 : head_ptr_reg + AW'(1);
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_ptr_reg  <= head_ptr_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.set_ok)
            begin
                ok_reg <= cmd.ok_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.head_zero)
        begin
            head_word_reg <= '0;
        end
        else if (cmd.head_cap)
        begin
            head_word_reg <= rd_data[WORD_W-1:0];
        end
    end

    assign count_wide = 32'(count_reg);

    // hold the word until taken; the next operation may already be in flight
    assign rsp_valid_next = cmd.out_load ? 1'b1 : (rsp_valid_reg && !response.ready);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_accepted_reg <= ok_reg;
            rsp_head_reg     <= head_word_reg;
            rsp_occ_reg      <= count_wide[OCC_W-1:0];
            rsp_empty_reg    <= (count_reg == '0);
        end
    end

    assign response.valid     = rsp_valid_reg;
    assign response.accepted  = rsp_accepted_reg;
    assign response.head_data = rsp_head_reg;
    assign response.occupancy = rsp_occ_reg;
    assign response.is_empty  = rsp_empty_reg;

    assign status.in_valid = request.valid;
    assign status.op       = op_reg;
    assign status.full     = (count_reg == CW'(DEPTH));
    assign status.empty    = (count_reg == '0);
    assign status.idx_zero = (idx_reg == '0);
    assign status.keep     = ($signed(rd_data[EW-1:WORD_W]) >= prio_reg);
    assign status.out_free = !rsp_valid_reg || response.ready;
endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks on the queue's response stream, bound to the top level.
// Depends on spq_pkg and stable_priority_queue.
module spq_checker #(
    parameter int DEPTH = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic                             accepted,
    input logic signed [spq_pkg::WORD_W-1:0] head_data,
    input logic [spq_pkg::OCC_W-1:0]        occupancy,
    input logic                             is_empty
);
    import spq_pkg::*;

    logic [OCC_W-1:0] last_occ_reg;
    logic             rsp_take;

    assign rsp_take = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_occ_reg <= '0;
        end
        else if (rsp_take)
        begin
            last_occ_reg <= occupancy;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(occupancy) && $stable(head_data))
        else $error("response word changed while stalled");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> head_data == '0)
        else $error("empty queue reports a nonzero head");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (DEPTH >= 32) || (is_empty == (occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && !accepted |-> occupancy == last_occ_reg)
        else $error("refused operation changed occupancy");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take |-> occupancy == last_occ_reg
                  || occupancy == OCC_W'(last_occ_reg + 1'b1)
                  || occupancy == OCC_W'(last_occ_reg - 1'b1)
                  || occupancy == '0)
        else $error("occupancy moved by more than one entry");
endmodule

bind stable_priority_queue spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .accepted  (response.accepted),
    .head_data (response.head_data),
    .occupancy (response.occupancy),
    .is_empty  (response.is_empty)
);

// ===== tb/tb_stable_priority_queue.sv =====
// Self-checking testbench for stable_priority_queue: drives request words with bursts
// and gaps, stalls the response side, and checks each response against a sorted queue.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the stable_priority_queue RTL.
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int RANDOM_OPS   = 1830;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_TRIGGER = 400;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        op_t                      op;
        logic signed [WORD_W-1:0] data;
        logic signed [WORD_W-1:0] prio;
        bit                       after_idle;
    } queue_op_t;

    typedef struct {
        logic                     accepted;
        logic signed [WORD_W-1:0] head;
        logic [OCC_W-1:0]         occ;
        logic                     empty;
    } queue_status_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue #(.DEPTH(QDEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    queue_op_t     op_backlog[$];
    queue_status_t status_due[$];

    // Sorted copy of the queue contents, head at index zero
    logic signed [WORD_W-1:0] held_words[QDEPTH];
    logic signed [WORD_W-1:0] held_prios[QDEPTH];
    int unsigned              held_count;

    int unsigned fail_count;
    int unsigned rsp_index;
    int unsigned ops_sent;
    int unsigned cycle_count;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned gap_max;

    int unsigned pattern_left;
    int unsigned pattern_kind;
    int unsigned hold_left;
    bit          hold_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic queue_status_t step_sorted_queue(queue_op_t item);
        queue_status_t st;
        int unsigned   pos;
        int unsigned   i;
        st.accepted = 1'b0;
        case (item.op)
            OP_ENQUEUE:
            begin
                if (held_count < QDEPTH)
                begin
                    // Land behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_count && held_prios[pos] >= item.prio)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_words[i] = held_words[i-1];
                        held_prios[i] = held_prios[i-1];
                    end
                    held_words[pos] = item.data;
                    held_prios[pos] = item.prio;
                    held_count++;
                    st.accepted = 1'b1;
                end
            end
            OP_DEQUEUE:
            begin
                if (held_count != 0)
                begin
                    for (i = 1; i < held_count; i++)
                    begin
                        held_words[i-1] = held_words[i];
                        held_prios[i-1] = held_prios[i];
                    end
                    held_count--;
                    st.accepted = 1'b1;
                end
            end
            OP_PEEK:
                st.accepted = (held_count != 0);
            default:
            begin
                held_count  = 0;
                st.accepted = 1'b1;
            end
        endcase
        st.head  = (held_count != 0) ? held_words[0] : '0;
        st.occ   = held_count[OCC_W-1:0];
        st.empty = (held_count == 0);
        return st;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (fail_count < PRINT_CAP)
            $display("mismatch at response %0d: %s got %0d want %0d",
                     rsp_index, what, got, want);
        fail_count++;
    endtask

    task automatic add_op(op_t op, logic signed [WORD_W-1:0] data,
                          logic signed [WORD_W-1:0] prio, bit after_idle);
        queue_op_t item;
        item.op         = op;
        item.data       = data;
        item.prio       = prio;
        item.after_idle = after_idle;
        op_backlog.push_back(item);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_prio();
        logic signed [WORD_W-1:0] p;
        case ($urandom_range(0, 5))
            0, 1, 2: p = $signed($urandom_range(0, 6)) - 3;     // many ties
            3:
            begin
                case ($urandom_range(0, 4))
                    0: p = 32'sh7fffffff;
                    1: p = 32'sh80000000;
                    2: p = 0;
                    3: p = -1;
                    default: p = 1;
                endcase
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    function automatic op_t pick_mixed_op();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return OP_ENQUEUE;
        else if (r < 15)
            return OP_DEQUEUE;
        else if (r < 19)
            return OP_PEEK;
        return OP_CLEAR;
    endfunction

    // Stimulus and end of run
    initial
    begin
        int unsigned len;
        int unsigned kind;
        bit          idle_flag;
        bit          first_seq;
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_PEEK;
        req_ch.data_in     = '0;
        req_ch.priority_in = '0;
        rsp_ch.ready       = 1'b0;
        held_count  = 0;
        fail_count  = 0;
        rsp_index   = 0;
        ops_sent    = 0;
        cycle_count = 0;
        burst_left  = 0;
        gap_left    = 0;
        gap_max     = 0;
        pattern_left = 0;
        pattern_kind = 0;
        hold_left    = 0;
        hold_done    = 1'b0;

        // Directed: empty cases, priority extremes, ties, clear
        add_op(OP_PEEK,    32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_ENQUEUE, 32'sh7fffffff,   32'sd0,          1'b0);
        add_op(OP_ENQUEUE, 32'sh80000000,   32'sh7fffffff,   1'b0);
        add_op(OP_ENQUEUE, 32'sd1,          32'sh80000000,   1'b0);
        add_op(OP_ENQUEUE, 32'sd2,          32'sd0,          1'b0);
        add_op(OP_ENQUEUE, 32'sd3,          32'sh7fffffff,   1'b0);
        add_op(OP_ENQUEUE, -32'sd1,         -32'sd1,         1'b0);
        add_op(OP_PEEK,    32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_CLEAR,   32'sd0,          32'sd0,          1'b0);
        add_op(OP_PEEK,    32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_CLEAR,   32'sd0,          32'sd0,          1'b0);
        add_op(OP_ENQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);
        add_op(OP_DEQUEUE, 32'sd0,          32'sd0,          1'b0);

        // Random: fill runs that often hit full, drain runs, mixed runs
        first_seq = 1'b1;
        while (op_backlog.size() < RANDOM_OPS + 20)
        begin
            kind      = $urandom_range(0, 9);
            len       = $urandom_range(1, 20);
            idle_flag = first_seq || ($urandom_range(0, 24) == 0);
            first_seq = 1'b0;
            for (int unsigned k = 0; k < len; k++)
            begin
                case (kind)
                    0, 1, 2:
                        add_op(($urandom_range(0, 7) == 0) ? OP_PEEK : OP_ENQUEUE,
                               $urandom, pick_prio(), idle_flag && k == 0);
                    3, 4:
                        add_op(($urandom_range(0, 5) == 0) ? OP_PEEK : OP_DEQUEUE,
                               $urandom, $urandom, idle_flag && k == 0);
                    9:
                        add_op((k == 0) ? OP_CLEAR : OP_ENQUEUE,
                               $urandom, pick_prio(), idle_flag && k == 0);
                    default:
                        add_op(pick_mixed_op(), $urandom, pick_prio(),
                               idle_flag && k == 0);
                endcase
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (op_backlog.size() != 0 || status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("tb_stable_priority_queue: PASS");
        else
            $display("tb_stable_priority_queue: FAIL");
        $finish;
    end

    // Request driver: bursts with random gaps, hold each word until taken
    always @(posedge clk)
    begin
        queue_op_t item;
        bit        offer;
        if (rst_n)
        begin
            offer = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                item = op_backlog.pop_front();
                status_due.push_back(step_sorted_queue(item));
                ops_sent++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
                if (gap_left != 0)
                    gap_left--;
                else if (op_backlog.size() != 0 &&
                         (!op_backlog[0].after_idle || status_due.size() == 0))
                begin
                    item = op_backlog[0];
                    req_ch.operation   <= item.op;
                    req_ch.data_in     <= item.data;
                    req_ch.priority_in <= item.prio;
                    offer = 1'b1;
                    burst_left--;
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end
            req_ch.valid <= offer;
        end
    end

    // Response ready: changing stall patterns plus one long hold-off
    always @(posedge clk)
    begin
        bit take;
        if (rst_n)
        begin
            take = 1'b0;
            if (hold_left != 0)
                hold_left--;
            else if (!hold_done && ops_sent >= HOLD_TRIGGER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_kind = $urandom_range(0, 3);
                    pattern_left = $urandom_range(10, 120);
                end
                pattern_left--;
                case (pattern_kind)
                    0: take = 1'b1;
                    1: take = $urandom_range(0, 1);
                    2: take = ($urandom_range(0, 3) == 0);
                    default: take = pattern_left[0];
                endcase
            end
            rsp_ch.ready <= take;
        end
    end

    // Response monitor: compare each taken word with the oldest prediction
    always @(posedge clk)
    begin
        queue_status_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (status_due.size() == 0)
                report_mismatch("unexpected response, occupancy", rsp_ch.occupancy, -1);
            else
            begin
                want = status_due.pop_front();
                if (rsp_ch.accepted !== want.accepted)
                    report_mismatch("accepted", rsp_ch.accepted, want.accepted);
                if (rsp_ch.head_data !== want.head)
                    report_mismatch("head_data", rsp_ch.head_data, want.head);
                if (rsp_ch.occupancy !== want.occ)
                    report_mismatch("occupancy", rsp_ch.occupancy, want.occ);
                if (rsp_ch.is_empty !== want.empty)
                    report_mismatch("is_empty", rsp_ch.is_empty, want.empty);
            end
            rsp_index++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_stable_priority_queue: FAIL");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_req_if.sv
hdl/spq_rsp_if.sv
hdl/spq_ram.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/stable_priority_queue.sv
hdl/spq_checker.sv
tb/tb_stable_priority_queue.sv
